/* sv/tpcs_pkg.sv */
package tpcs_pkg;

	localparam int COUNT_BITS = 8;
	localparam int CFG_AW     = 5;
	localparam int CFG_DW     = 32;

	typedef logic [COUNT_BITS-1:0] cnt_t;
	typedef logic [1:0]            pstate_t;

	localparam pstate_t ST_READY   = 2'd0;
	localparam pstate_t ST_RUNNING = 2'd1;
	localparam pstate_t ST_WAITING = 2'd2;
	localparam pstate_t ST_DONE    = 2'd3;

	localparam logic [1:0] POL_FCFS = 2'd0;
	localparam logic [1:0] POL_SJF  = 2'd1;
	localparam logic [1:0] POL_PSJF = 2'd2;
	localparam logic [1:0] POL_RR   = 2'd3;

	localparam logic [2:0] REG_POLICY   = 3'd0;
	localparam logic [2:0] REG_QUANTUM  = 3'd1;
	localparam logic [2:0] REG_FIRST_A  = 3'd2;
	localparam logic [2:0] REG_IO_A     = 3'd3;
	localparam logic [2:0] REG_SECOND_A = 3'd4;
	localparam logic [2:0] REG_FIRST_B  = 3'd5;
	localparam logic [2:0] REG_IO_B     = 3'd6;
	localparam logic [2:0] REG_SECOND_B = 3'd7;

	typedef struct packed {
		logic [1:0] policy;
		logic [7:0] quantum;
		logic [7:0] first_a;
		logic [7:0] io_a;
		logic [7:0] second_a;
		logic [7:0] first_b;
		logic [7:0] io_b;
		logic [7:0] second_b;
	} cfg_t;

	typedef struct packed {
		pstate_t state_a;
		pstate_t state_b;
		cnt_t    cpu_a;
		cnt_t    cpu_b;
		cnt_t    io_a;
		cnt_t    io_b;
		cnt_t    slice;
	} sched_t;

endpackage

/* sv/tpcs_if.sv */
interface tpcs_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface tpcs_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] proc_a_state;
	logic [1:0] proc_b_state;
	logic       finished;

	modport source (output valid, output proc_a_state, output proc_b_state,
		output finished, input ready);
	modport sink (input valid, input proc_a_state, input proc_b_state,
		input finished, output ready);
endinterface

/* sv/tpcs_cfg.sv */
module tpcs_cfg
	import tpcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[CFG_AW-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.policy   <= POL_FCFS;
			cfg_q.quantum  <= 8'd1;
			cfg_q.first_a  <= 8'd1;
			cfg_q.io_a     <= 8'd1;
			cfg_q.second_a <= 8'd1;
			cfg_q.first_b  <= 8'd1;
			cfg_q.io_b     <= 8'd1;
			cfg_q.second_b <= 8'd1;
		end else if (wr) begin
			case (idx)
				REG_POLICY:   cfg_q.policy   <= pwdata[1:0];
				REG_QUANTUM:  cfg_q.quantum  <= pwdata[7:0];
				REG_FIRST_A:  cfg_q.first_a  <= pwdata[7:0];
				REG_IO_A:     cfg_q.io_a     <= pwdata[7:0];
				REG_SECOND_A: cfg_q.second_a <= pwdata[7:0];
				REG_FIRST_B:  cfg_q.first_b  <= pwdata[7:0];
				REG_IO_B:     cfg_q.io_b     <= pwdata[7:0];
				REG_SECOND_B: cfg_q.second_b <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_POLICY:   prdata = CFG_DW'(cfg_q.policy);
			REG_QUANTUM:  prdata = CFG_DW'(cfg_q.quantum);
			REG_FIRST_A:  prdata = CFG_DW'(cfg_q.first_a);
			REG_IO_A:     prdata = CFG_DW'(cfg_q.io_a);
			REG_SECOND_A: prdata = CFG_DW'(cfg_q.second_a);
			REG_FIRST_B:  prdata = CFG_DW'(cfg_q.first_b);
			REG_IO_B:     prdata = CFG_DW'(cfg_q.io_b);
			REG_SECOND_B: prdata = CFG_DW'(cfg_q.second_b);
			default:      prdata = '0;
		endcase
	end

endmodule

/* sv/tpcs_step.sv */
module tpcs_step
	import tpcs_pkg::*;
(
	input  logic   restart,
	input  cfg_t   cfg,
	input  sched_t cur,
	output sched_t nxt
);

	function automatic cnt_t dec_sat(input cnt_t v);
		return (v == '0) ? v : v - cnt_t'(1);
	endfunction

	sched_t s;
	cnt_t   quant;

	assign quant = cnt_t'(cfg.quantum);

	always_comb begin
		s = cur;
		if (restart) begin
			s.state_a = ST_READY;
			s.state_b = ST_READY;
			s.cpu_a   = cnt_t'(cfg.first_a);
			s.cpu_b   = cnt_t'(cfg.first_b);
			s.io_a    = cnt_t'(cfg.io_a);
			s.io_b    = cnt_t'(cfg.io_b);
			s.slice   = quant;
		end

		// burst end, at most one per tick
		if (s.state_a == ST_RUNNING && s.cpu_a == '0) begin
			s.state_a = (s.io_a == '0) ? ST_DONE : ST_WAITING;
		end else if (s.state_b == ST_RUNNING && s.cpu_b == '0) begin
			s.state_b = (s.io_b == '0) ? ST_DONE : ST_WAITING;
		end

		// slice expiry
		if (cfg.policy == POL_RR) begin
			if (s.state_a == ST_RUNNING && s.slice == '0) begin
				s.state_a = ST_READY;
				if (s.state_b == ST_READY) begin
					s.state_b = ST_RUNNING;
					s.slice   = quant;
				end
			end
			if (s.state_b == ST_RUNNING && s.slice == '0) begin
				s.state_b = ST_READY;
				if (s.state_a == ST_READY) begin
					s.state_a = ST_RUNNING;
					s.slice   = quant;
				end
			end
		end

		// I/O return
		if (s.state_a == ST_WAITING && s.io_a == '0) begin
			s.state_a = ST_READY;
			s.cpu_a   = cnt_t'(cfg.second_a);
			if (cfg.policy == POL_PSJF && s.cpu_a < s.cpu_b) begin
				s.state_a = ST_RUNNING;
				s.state_b = ST_READY;
			end
		end
		if (s.state_b == ST_WAITING && s.io_b == '0) begin
			s.state_b = ST_READY;
			s.cpu_b   = cnt_t'(cfg.second_b);
			if (cfg.policy == POL_PSJF && s.cpu_a > s.cpu_b) begin
				s.state_b = ST_RUNNING;
				s.state_a = ST_READY;
			end
		end

		// dispatch, ties go to A
		if (s.state_a == ST_READY && s.state_b == ST_READY) begin
			if ((cfg.policy inside {POL_SJF, POL_PSJF}) && s.cpu_a > s.cpu_b) begin
				s.state_b = ST_RUNNING;
			end else begin
				s.state_a = ST_RUNNING;
			end
			s.slice = quant;
		end else if (s.state_a == ST_READY && s.state_b != ST_RUNNING) begin
			s.state_a = ST_RUNNING;
			s.slice   = quant;
		end else if (s.state_b == ST_READY && s.state_a != ST_RUNNING) begin
			s.state_b = ST_RUNNING;
			s.slice   = quant;
		end

		// count down
		s.slice = dec_sat(s.slice);
		if (s.state_a == ST_RUNNING) begin
			s.cpu_a = dec_sat(s.cpu_a);
		end
		if (s.state_a == ST_WAITING) begin
			s.io_a = dec_sat(s.io_a);
		end
		if (s.state_b == ST_RUNNING) begin
			s.cpu_b = dec_sat(s.cpu_b);
		end
		if (s.state_b == ST_WAITING) begin
			s.io_b = dec_sat(s.io_b);
		end

		nxt = s;
	end

endmodule

/* sv/two_process_cpu_scheduler_core.sv */
// Two-process tick scheduler. Each accepted request on req is one tick; the
// tick applies burst end, round-robin slice expiry, I/O return, dispatch and
// countdown in that order and returns both process states and a finished flag
// on rsp. One tick per cycle: the next state is computed in one pass from the
// state registers, and a single output register holds the response, so a new
// request is taken whenever that register is empty or being drained. The
// response is valid in the cycle after its request is accepted. Policy,
// quantum and burst lengths are programmed over the APB port (register i at
// byte address 4*i) and loaded into the counters when a tick carries restart.
module two_process_cpu_scheduler_core
	import tpcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	tpcs_req_if.sink          req,
	tpcs_rsp_if.source        rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	cfg_t    cfg;
	sched_t  st_q;
	sched_t  nxt;
	logic    out_valid_q;
	pstate_t out_a_q;
	pstate_t out_b_q;
	logic    out_fin_q;
	logic    accept;

	tpcs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tpcs_step u_step (
		.restart (req.restart),
		.cfg     (cfg),
		.cur     (st_q),
		.nxt     (nxt)
	);

	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.state_a <= ST_DONE;
			st_q.state_b <= ST_DONE;
			st_q.cpu_a   <= '0;
			st_q.cpu_b   <= '0;
			st_q.io_a    <= '0;
			st_q.io_b    <= '0;
			st_q.slice   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				st_q        <= nxt;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_a_q   <= nxt.state_a;
			out_b_q   <= nxt.state_b;
			out_fin_q <= (nxt.state_a == ST_DONE) && (nxt.state_b == ST_DONE);
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.proc_a_state = out_a_q;
	assign rsp.proc_b_state = out_b_q;
	assign rsp.finished     = out_fin_q;

`ifndef ASSERT_OFF
	a_one_running: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_q.state_a == ST_RUNNING && st_q.state_b == ST_RUNNING))
		else $error("both processes running");

	a_fin_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.finished ==
		(rsp.proc_a_state == ST_DONE && rsp.proc_b_state == ST_DONE)))
		else $error("finished flag disagrees with states");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |-> !req.ready)
		else $error("request taken over a stalled response");

	a_resp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (rsp.valid && st_q == $past(nxt)))
		else $error("accepted request gave no response");
`endif

endmodule

/* test/tb_two_process_cpu_scheduler_core.sv */
module tb_two_process_cpu_scheduler_core;
	import tpcs_pkg::*;

	typedef struct packed {
		pstate_t a;
		pstate_t b;
		logic    fin;
	} tick_view_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic pready;

	tpcs_req_if req_ch ();
	tpcs_rsp_if rsp_ch ();

	two_process_cpu_scheduler_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the programmed registers and of the scheduler state
	cfg_t    cfg;
	pstate_t sched_a, sched_b;
	cnt_t    cpu_a, cpu_b, io_a, io_b, slice;

	tick_view_t pending_views[$];

	int snd_idle_pct;
	int rcv_stall_pct;
	int n_errors;
	int n_ticks;
	int n_restarts;
	int n_results;
	int n_writes;
	int n_runs_done;
	logic [3:0] policies_seen;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		#4000000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(string field, int got, int want);
		$display("mismatch on %s at response %0d: got %0d, want %0d", field, n_results, got,
			want);
		n_errors++;
	endtask

	function automatic cnt_t dec_floor(cnt_t v);
		return (v == '0) ? v : v - 1'b1;
	endfunction

	function automatic logic sched_done();
		return sched_a == ST_DONE && sched_b == ST_DONE;
	endfunction

	function automatic void advance_schedule(logic rst);
		tick_view_t v;
		if (rst) begin
			sched_a = ST_READY;
			sched_b = ST_READY;
			cpu_a = cfg.first_a;
			cpu_b = cfg.first_b;
			io_a = cfg.io_a;
			io_b = cfg.io_b;
			slice = cfg.quantum;
		end
		// burst end, A first, at most one per tick
		if (sched_a == ST_RUNNING && cpu_a == '0)
			sched_a = (io_a == '0) ? ST_DONE : ST_WAITING;
		else if (sched_b == ST_RUNNING && cpu_b == '0)
			sched_b = (io_b == '0) ? ST_DONE : ST_WAITING;
		if (cfg.policy == POL_RR) begin
			if (sched_a == ST_RUNNING && slice == '0) begin
				sched_a = ST_READY;
				if (sched_b == ST_READY) begin
					sched_b = ST_RUNNING;
					slice = cfg.quantum;
				end
			end
			if (sched_b == ST_RUNNING && slice == '0) begin
				sched_b = ST_READY;
				if (sched_a == ST_READY) begin
					sched_a = ST_RUNNING;
					slice = cfg.quantum;
				end
			end
		end
		if (sched_a == ST_WAITING && io_a == '0) begin
			sched_a = ST_READY;
			cpu_a = cfg.second_a;
			if (cfg.policy == POL_PSJF && cpu_a < cpu_b) begin
				sched_a = ST_RUNNING;
				sched_b = ST_READY;
			end
		end
		if (sched_b == ST_WAITING && io_b == '0) begin
			sched_b = ST_READY;
			cpu_b = cfg.second_b;
			if (cfg.policy == POL_PSJF && cpu_a > cpu_b) begin
				sched_b = ST_RUNNING;
				sched_a = ST_READY;
			end
		end
		if (sched_a == ST_READY && sched_b == ST_READY) begin
			if ((cfg.policy == POL_SJF || cfg.policy == POL_PSJF) && cpu_a > cpu_b)
				sched_b = ST_RUNNING;
			else
				sched_a = ST_RUNNING;
			slice = cfg.quantum;
		end else if (sched_a == ST_READY && sched_b != ST_RUNNING) begin
			sched_a = ST_RUNNING;
			slice = cfg.quantum;
		end else if (sched_b == ST_READY && sched_a != ST_RUNNING) begin
			sched_b = ST_RUNNING;
			slice = cfg.quantum;
		end
		slice = dec_floor(slice);
		if (sched_a == ST_RUNNING)
			cpu_a = dec_floor(cpu_a);
		if (sched_a == ST_WAITING)
			io_a = dec_floor(io_a);
		if (sched_b == ST_RUNNING)
			cpu_b = dec_floor(cpu_b);
		if (sched_b == ST_WAITING)
			io_b = dec_floor(io_b);
		v.a = sched_a;
		v.b = sched_b;
		v.fin = sched_done();
		pending_views.push_back(v);
	endfunction

	task automatic send_tick(logic rst);
		int gap;
		gap = 0;
		while (gap < 8 && $urandom_range(0, 99) < snd_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.restart <= rst;
		do @(posedge clk); while (!req_ch.ready);
		advance_schedule(rst);
		n_ticks++;
		if (rst)
			n_restarts++;
		policies_seen[cfg.policy] = 1'b1;
	endtask

	always @(posedge clk) begin
		tick_view_t w;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_results++;
				if (pending_views.size() == 0) begin
					report_mismatch("unexpected response", 1, 0);
				end else begin
					w = pending_views.pop_front();
					if (rsp_ch.proc_a_state !== w.a)
						report_mismatch("proc_a_state", rsp_ch.proc_a_state, w.a);
					if (rsp_ch.proc_b_state !== w.b)
						report_mismatch("proc_b_state", rsp_ch.proc_b_state, w.b);
					if (rsp_ch.finished !== w.fin)
						report_mismatch("finished", rsp_ch.finished, w.fin);
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
		end
	end

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (pending_views.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [7:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_POLICY:   cfg.policy = val[1:0];
			REG_QUANTUM:  cfg.quantum = val;
			REG_FIRST_A:  cfg.first_a = val;
			REG_IO_A:     cfg.io_a = val;
			REG_SECOND_A: cfg.second_a = val;
			REG_FIRST_B:  cfg.first_b = val;
			REG_IO_B:     cfg.io_b = val;
			REG_SECOND_B: cfg.second_b = val;
			default: ;
		endcase
		n_writes++;
		@(posedge clk);
	endtask

	task automatic program_all(cfg_t c);
		write_reg(REG_POLICY, {6'd0, c.policy});
		write_reg(REG_QUANTUM, c.quantum);
		write_reg(REG_FIRST_A, c.first_a);
		write_reg(REG_IO_A, c.io_a);
		write_reg(REG_SECOND_A, c.second_a);
		write_reg(REG_FIRST_B, c.first_b);
		write_reg(REG_IO_B, c.io_b);
		write_reg(REG_SECOND_B, c.second_b);
	endtask

	// ticks after a restart until both are done, with stray restarts mixed in
	task automatic run_ticks(int cap, int restart_pct);
		int k;
		k = 0;
		while (!sched_done() && k < cap) begin
			send_tick($urandom_range(0, 99) < restart_pct);
			k++;
		end
		if (sched_done())
			n_runs_done++;
	endtask

	function automatic logic [7:0] pick_len();
		if ($urandom_range(0, 15) == 0)
			return 8'($urandom_range(6, 40));
		return 8'($urandom_range(0, 5));
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.policy = 2'($urandom_range(0, 3));
		c.quantum = pick_len();
		c.first_a = pick_len();
		c.io_a = pick_len();
		c.second_a = pick_len();
		c.first_b = pick_len();
		c.io_b = pick_len();
		c.second_b = pick_len();
		return c;
	endfunction

	task automatic test_directed();
		cfg_t runs[4];
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		// idle ticks straight out of reset, then one run on reset values
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		// zero first burst and zero I/O on A
		runs[0] = '{POL_FCFS, 8'd1, 8'd0, 8'd0, 8'd1, 8'd2, 8'd1, 8'd1};
		// shorter job on B, quantum zero but unused
		runs[1] = '{POL_SJF, 8'd0, 8'd3, 8'd1, 8'd1, 8'd1, 8'd2, 8'd1};
		// A back from I/O with a short burst preempts B
		runs[2] = '{POL_PSJF, 8'd2, 8'd1, 8'd1, 8'd1, 8'd4, 8'd1, 8'd2};
		// zero quantum: slice expires every tick
		runs[3] = '{POL_RR, 8'd0, 8'd2, 8'd1, 8'd2, 8'd2, 8'd1, 8'd2};
		foreach (runs[i]) begin
			wait_drained();
			program_all(runs[i]);
			send_tick(1'b1);
			repeat (4) send_tick(1'b0);
		end
	endtask

	task automatic test_extremes();
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		wait_drained();
		program_all('{POL_RR, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
		send_tick(1'b1);
		run_ticks(300, 0);
		wait_drained();
		program_all('{POL_FCFS, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
		send_tick(1'b1);
		run_ticks(20, 0);
		send_tick(1'b0);
		wait_drained();
		program_all('{POL_PSJF, 8'd1, 8'd255, 8'd1, 8'd1, 8'd3, 8'd0, 8'd255});
		send_tick(1'b1);
		run_ticks(40, 0);
	endtask

	task automatic test_random_phase(int snd, int rcv, int n);
		int start;
		snd_idle_pct = snd;
		rcv_stall_pct = rcv;
		start = n_ticks;
		while (n_ticks - start < n) begin
			wait_drained();
			program_all(random_cfg());
			send_tick(1'b1);
			run_ticks(120, 4);
			repeat ($urandom_range(0, 2)) send_tick(1'b0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.restart = 1'b0;
		rsp_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		n_errors = 0;
		n_ticks = 0;
		n_restarts = 0;
		n_results = 0;
		n_writes = 0;
		n_runs_done = 0;
		policies_seen = '0;
		cfg = '{POL_FCFS, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1};
		sched_a = ST_DONE;
		sched_b = ST_DONE;
		cpu_a = '0;
		cpu_b = '0;
		io_a = '0;
		io_b = '0;
		slice = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_extremes();
		test_random_phase(0, 0, 300);
		test_random_phase(52, 0, 300);
		test_random_phase(0, 52, 300);
		test_random_phase(20, 20, 300);
		wait_drained();
		repeat (5) @(posedge clk);

		$display("ran %0d ticks with %0d restarts over %0d register writes; %0d responses checked",
			n_ticks, n_restarts, n_writes, n_results);
		$display("policies used %b, %0d runs brought both processes to done",
			policies_seen, n_runs_done);
		if (n_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
